// ===== rtl/nmea_rmc_position_parser_assert.svh =====
// ---------------------------------------------------------------------------
// nmea_rmc_position_parser assertion macros
// Concurrent checks on aclk, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define RMCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define RMCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define RMCP_ASSERT(lbl, prop, msg)
`define RMCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/rmcp_pkg.sv =====
// ---------------------------------------------------------------------------
// rmcp_pkg
// Shared types, character codes and constant tables of the RMC parser.
// ---------------------------------------------------------------------------
package rmcp_pkg;

    localparam int FRAC_W = 20;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [3:0] FLD_TAG  = 4'd0;
    localparam logic [3:0] FLD_TIME = 4'd1;
    localparam logic [3:0] FLD_STAT = 4'd2;
    localparam logic [3:0] FLD_LAT  = 4'd3;
    localparam logic [3:0] FLD_NS   = 4'd4;
    localparam logic [3:0] FLD_LON  = 4'd5;
    localparam logic [3:0] FLD_EW   = 4'd6;

    localparam logic [16:0] INT_PART_MAX = 17'd131071;
    localparam logic [34:0] LAT_MAX      = 35'd900000000;
    localparam logic [34:0] LON_MAX      = 35'd1800000000;

    typedef struct packed {
        logic [6:0]        hour;
        logic [6:0]        minute;
        logic [31:0]       sec_ms;
        logic [16:0]       lat_ip;
        logic [FRAC_W-1:0] lat_fp;
        logic [16:0]       lon_ip;
        logic [FRAC_W-1:0] lon_fp;
        logic              south;
        logic              west;
    } line_rec_t;

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        case (idx)
            3'd0:    tag_char = 8'h24;
            3'd1:    tag_char = 8'h47;
            3'd2:    tag_char = 8'h50;
            3'd3:    tag_char = 8'h52;
            3'd4:    tag_char = 8'h4D;
            3'd5:    tag_char = 8'h43;
            default: tag_char = 8'h00;
        endcase
    endfunction

    function automatic logic [23:0] pow10(input logic [2:0] n);
        case (n)
            3'd0:    pow10 = 24'd1;
            3'd1:    pow10 = 24'd10;
            3'd2:    pow10 = 24'd100;
            3'd3:    pow10 = 24'd1000;
            3'd4:    pow10 = 24'd10000;
            3'd5:    pow10 = 24'd100000;
            3'd6:    pow10 = 24'd1000000;
            3'd7:    pow10 = 24'd10000000;
            default: pow10 = 24'd1;
        endcase
    endfunction

    function automatic logic [6:0] ms_weight(input logic [2:0] k);
        case (k)
            3'd0:    ms_weight = 7'd100;
            3'd1:    ms_weight = 7'd10;
            3'd2:    ms_weight = 7'd1;
            default: ms_weight = 7'd0;
        endcase
    endfunction

endpackage

// ===== rtl/nmea_rmc_position_parser.sv =====
// ---------------------------------------------------------------------------
// nmea_rmc_position_parser
// NMEA $GPRMC sentence parser giving relative time and position.
// ---------------------------------------------------------------------------
// Input s_*: one text character per word, valid/ready. Output m_*: one word
// per qualifying line with ms since the first fix and lat/lon in deg*1e7.
// The tokenizer takes one character per cycle; s_ready drops only while the
// two-entry record queue is full. A line record is queued at its newline and
// the converter takes one record at a time through load, four arithmetic
// steps and commit, and registers the result at commit. Since a qualifying
// line has at least 16 characters, the sustained input rate is one character
// per cycle. If m_ready is held low the output register
// holds its word, the converter waits, then the queue fills and s_ready
// falls. Synchronous active-low reset clears the line state, the queue,
// the output valid and the latched first fix time.
// ---------------------------------------------------------------------------
module nmea_rmc_position_parser #(
    parameter int MINUTE_FRAC_DIGITS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_char_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_rel_time_ms,
    output logic signed [30:0]  m_latitude_e7,
    output logic signed [31:0]  m_longitude_e7
);
    import rmcp_pkg::*;

    line_rec_t push_data, pop_data;
    logic      push, pop, full, empty;

    rmcp_front #(.MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_byte(s_char_byte),
        .q_full(full), .q_push(push), .q_data(push_data)
    );

    rmcp_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .wdata(push_data), .pop(pop), .rdata(pop_data),
        .full(full), .empty(empty)
    );

    rmcp_back #(.MINUTE_FRAC_DIGITS(MINUTE_FRAC_DIGITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(empty), .q_data(pop_data), .q_pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rel_time_ms(m_rel_time_ms), .m_latitude_e7(m_latitude_e7),
        .m_longitude_e7(m_longitude_e7)
    );
endmodule

// ===== rtl/rmcp_front.sv =====
// ---------------------------------------------------------------------------
// rmcp_front
// Character-rate line tokenizer; emits one line record per valid RMC line.
// ---------------------------------------------------------------------------
module rmcp_front #(
    parameter int MINUTE_FRAC_DIGITS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_char_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output rmcp_pkg::line_rec_t  q_data
);
    import rmcp_pkg::*;

    localparam logic [2:0] FD = 3'(MINUTE_FRAC_DIGITS);

    logic [3:0]        fld_reg;
    logic [6:0]        pos_reg;
    logic              prefix_ok_reg, status_ok_reg, south_reg, west_reg;
    logic [31:0]       sec_ms_reg;
    logic [6:0]        tlen_reg, hour_reg, minute_reg;
    logic [16:0]       lat_ip_reg, lon_ip_reg;
    logic [FRAC_W-1:0] lat_fp_reg, lon_fp_reg;
    logic              stop_reg, dot_reg;
    logic [2:0]        fcnt_reg;

    logic        acc, is_dig, is_blank, nc_int, nc_frac, dot_set, stop_set;
    logic [3:0]  dig;
    logic [2:0]  fcnt_next, k;
    logic [16:0] lat_ip_next, lon_ip_next;
    logic [FRAC_W-1:0] lat_fp_next, lon_fp_next;
    logic        stop_eff, stop_t;

    function automatic logic [16:0] ip_step(input logic [16:0] ip, input logic [3:0] d);
        logic [20:0] v;
        v = {4'd0, ip} * 21'd10 + {17'd0, d};
        ip_step = (v > {4'd0, INT_PART_MAX}) ? INT_PART_MAX : v[16:0];
    endfunction

    function automatic logic [FRAC_W-1:0] fp_step(input logic [FRAC_W-1:0] fp,
                                                 input logic [3:0] d,
                                                 input logic [2:0] kk);
        logic [23:0] w;
        w = pow10(3'(FD - 3'd1 - kk));
        fp_step = (kk < FD) ? FRAC_W'(fp + FRAC_W'({20'd0, d} * w)) : fp;
    endfunction

    assign s_ready  = !q_full;
    assign acc      = s_valid && s_ready;
    assign is_dig   = (s_char_byte >= CH_ZERO) && (s_char_byte <= CH_NINE);
    assign dig      = 4'(s_char_byte - CH_ZERO);
    assign is_blank = (s_char_byte == CH_SP) || (s_char_byte == CH_TAB)
                   || (s_char_byte == CH_VT) || (s_char_byte == CH_FF);

    assign nc_int    = !stop_reg && is_dig && !dot_reg;
    assign nc_frac   = !stop_reg && is_dig && dot_reg;
    assign dot_set   = !stop_reg && !is_dig && (s_char_byte == CH_DOT) && !dot_reg;
    assign stop_set  = !stop_reg && !is_dig && !dot_set;
    assign fcnt_next = (nc_frac && fcnt_reg != 3'd7) ? fcnt_reg + 3'd1 : fcnt_reg;
    assign k         = fcnt_next - 3'd1;

    assign lat_ip_next = ip_step(lat_ip_reg, dig);
    assign lon_ip_next = ip_step(lon_ip_reg, dig);
    assign lat_fp_next = fp_step(lat_fp_reg, dig, k);
    assign lon_fp_next = fp_step(lon_fp_reg, dig, k);

    assign stop_eff = (pos_reg == 7'd0 || pos_reg == 7'd2) ? 1'b0 : stop_reg;
    assign stop_t   = (pos_reg == 7'd3) ? 1'b0 : (stop_eff || !is_dig);

    assign q_push = acc && (s_char_byte == CH_LF) && prefix_ok_reg && status_ok_reg
                 && (tlen_reg >= 7'd6);
    always_comb begin
        q_data.hour   = hour_reg;
        q_data.minute = minute_reg;
        q_data.sec_ms = sec_ms_reg;
        q_data.lat_ip = lat_ip_reg;
        q_data.lat_fp = lat_fp_reg;
        q_data.lon_ip = lon_ip_reg;
        q_data.lon_fp = lon_fp_reg;
        q_data.south  = south_reg;
        q_data.west   = west_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (acc && s_char_byte == CH_LF)) begin
            fld_reg <= '0; pos_reg <= '0; prefix_ok_reg <= 1'b0; status_ok_reg <= 1'b0;
            sec_ms_reg <= '0; tlen_reg <= '0; hour_reg <= '0; minute_reg <= '0;
            lat_ip_reg <= '0; lat_fp_reg <= '0; lon_ip_reg <= '0; lon_fp_reg <= '0;
            south_reg <= 1'b0; west_reg <= 1'b0;
            stop_reg <= 1'b0; dot_reg <= 1'b0; fcnt_reg <= '0;
        end else if (acc && s_char_byte != CH_CR
                     && !(fld_reg == FLD_TAG && pos_reg == 7'd0 && is_blank)) begin
            if (s_char_byte == CH_COMMA) begin
                if (fld_reg == FLD_TAG && pos_reg < 7'd6) prefix_ok_reg <= 1'b0;
                if (fld_reg != 4'd15) fld_reg <= fld_reg + 4'd1;
                pos_reg  <= '0;
                stop_reg <= 1'b0;
                dot_reg  <= 1'b0;
                fcnt_reg <= '0;
            end else begin
                case (fld_reg)
                    FLD_TAG: begin
                        if (pos_reg < 7'd6)
                            prefix_ok_reg <= (s_char_byte == tag_char(pos_reg[2:0]))
                                          && (pos_reg == 7'd0 || prefix_ok_reg);
                    end
                    FLD_TIME: begin
                        if (tlen_reg != 7'd127) tlen_reg <= tlen_reg + 7'd1;
                        if (pos_reg < 7'd4) begin
                            if (!stop_eff && is_dig) begin
                                if (pos_reg < 7'd2)
                                    hour_reg <= 7'(hour_reg * 7'd10 + {3'd0, dig});
                                else
                                    minute_reg <= 7'(minute_reg * 7'd10 + {3'd0, dig});
                            end
                            stop_reg <= stop_t;
                        end else begin
                            if (nc_int)
                                sec_ms_reg <= sec_ms_reg * 32'd10 + {28'd0, dig} * 32'd1000;
                            else if (nc_frac && k < 3'd3)
                                sec_ms_reg <= sec_ms_reg + {28'd0, dig} * {25'd0, ms_weight(k)};
                            if (dot_set) dot_reg <= 1'b1;
                            if (stop_set) stop_reg <= 1'b1;
                            fcnt_reg <= fcnt_next;
                        end
                    end
                    FLD_STAT: status_ok_reg <= (pos_reg == 7'd0) && (s_char_byte == CH_A);
                    FLD_LAT: begin
                        if (nc_int) lat_ip_reg <= lat_ip_next;
                        if (nc_frac) lat_fp_reg <= lat_fp_next;
                        if (dot_set) dot_reg <= 1'b1;
                        if (stop_set) stop_reg <= 1'b1;
                        fcnt_reg <= fcnt_next;
                    end
                    FLD_NS: if (pos_reg == 7'd0) south_reg <= (s_char_byte == CH_S);
                    FLD_LON: begin
                        if (nc_int) lon_ip_reg <= lon_ip_next;
                        if (nc_frac) lon_fp_reg <= lon_fp_next;
                        if (dot_set) dot_reg <= 1'b1;
                        if (stop_set) stop_reg <= 1'b1;
                        fcnt_reg <= fcnt_next;
                    end
                    FLD_EW: if (pos_reg == 7'd0) west_reg <= (s_char_byte == CH_W);
                    default: ;
                endcase
                if (pos_reg != 7'd127) pos_reg <= pos_reg + 7'd1;
            end
        end
    end
endmodule

// ===== rtl/rmcp_fifo.sv =====
// ---------------------------------------------------------------------------
// rmcp_fifo
// Two-entry queue of line records between tokenizer and converter.
// ---------------------------------------------------------------------------
module rmcp_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rmcp_pkg::line_rec_t  wdata,
    input  logic                 pop,
    output rmcp_pkg::line_rec_t  rdata,
    output logic                 full,
    output logic                 empty
);
    import rmcp_pkg::*;

    `include "nmea_rmc_position_parser_assert.svh"

    line_rec_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `RMCP_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
    `RMCP_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")
    `RMCP_ASSERT(a_cnt_range, cnt_reg != 2'd3, "queue count out of range")
endmodule

// ===== rtl/rmcp_back.sv =====
// ---------------------------------------------------------------------------
// rmcp_back
// Converts a line record to relative time and degrees*1e7 over five steps.
// ---------------------------------------------------------------------------
module rmcp_back #(
    parameter int MINUTE_FRAC_DIGITS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  rmcp_pkg::line_rec_t  q_data,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_rel_time_ms,
    output logic signed [30:0]   m_latitude_e7,
    output logic signed [31:0]   m_longitude_e7
);
    import rmcp_pkg::*;

    localparam logic [23:0] P_7MF = pow10(3'(7 - MINUTE_FRAC_DIGITS));
    localparam logic [17:0] M100  = 18'd167773;      // ceil(2^24/100)
    localparam logic [30:0] M60   = 31'd1145324613;  // ceil(2^36/60)

    logic        busy_reg;
    logic [2:0]  step_reg;
    line_rec_t   rec_reg;
    logic [34:0] lqp_reg, oqp_reg;
    logic [31:0] hms_reg, mms_reg, abs_reg, first_reg;
    logic [10:0] lq_reg, oq_reg;
    logic [6:0]  lr_reg, or_reg;
    logic [29:0] lt_reg, ot_reg;
    logic [60:0] lpr_reg, opr_reg;
    logic        mvalid_reg;
    logic [31:0] rel_reg, lon_reg;
    logic [30:0] lat_reg;

    logic        commit;
    logic [34:0] lmag, omag, lsat, osat;
    logic [31:0] ft_next, lneg, oneg;

    function automatic logic [29:0] t_calc(input logic [6:0] r, input logic [FRAC_W-1:0] fp);
        t_calc = 30'({23'd0, r} * 30'd10000000 + {10'd0, fp} * {6'd0, P_7MF});
    endfunction

    assign q_pop  = !busy_reg && !q_empty;
    assign commit = busy_reg && step_reg == 3'd5 && (!mvalid_reg || m_ready);

    assign lmag = {24'd0, lq_reg} * 35'd10000000 + {10'd0, lpr_reg[60:36]};
    assign omag = {24'd0, oq_reg} * 35'd10000000 + {10'd0, opr_reg[60:36]};
    assign lsat = (lmag > LAT_MAX) ? LAT_MAX : lmag;
    assign osat = (omag > LON_MAX) ? LON_MAX : omag;
    assign lneg = rec_reg.south ? 32'd0 - lsat[31:0] : lsat[31:0];
    assign oneg = rec_reg.west  ? 32'd0 - osat[31:0] : osat[31:0];
    assign ft_next = (first_reg == 32'd0) ? abs_reg : first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; step_reg <= '0; mvalid_reg <= 1'b0; first_reg <= '0;
        end else begin
            if (q_pop) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd1;
            end else if (busy_reg && step_reg != 3'd5) begin
                step_reg <= step_reg + 3'd1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (commit) begin
                mvalid_reg <= 1'b1;
                first_reg  <= ft_next;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) rec_reg <= q_data;
        case (step_reg)
            3'd1: begin
                lqp_reg <= {18'd0, rec_reg.lat_ip} * {17'd0, M100};
                oqp_reg <= {18'd0, rec_reg.lon_ip} * {17'd0, M100};
                hms_reg <= {25'd0, rec_reg.hour} * 32'd3600000;
                mms_reg <= {25'd0, rec_reg.minute} * 32'd60000;
            end
            3'd2: begin
                lq_reg  <= lqp_reg[34:24];
                oq_reg  <= oqp_reg[34:24];
                lr_reg  <= 7'(rec_reg.lat_ip - 17'(lqp_reg[34:24] * 17'd100));
                or_reg  <= 7'(rec_reg.lon_ip - 17'(oqp_reg[34:24] * 17'd100));
                abs_reg <= hms_reg + mms_reg + rec_reg.sec_ms;
            end
            3'd3: begin
                lt_reg <= t_calc(lr_reg, rec_reg.lat_fp);
                ot_reg <= t_calc(or_reg, rec_reg.lon_fp);
            end
            3'd4: begin
                lpr_reg <= {31'd0, lt_reg} * {30'd0, M60};
                opr_reg <= {31'd0, ot_reg} * {30'd0, M60};
            end
            default: ;
        endcase
        if (commit) begin
            rel_reg <= abs_reg - ft_next;
            lat_reg <= lneg[30:0];
            lon_reg <= oneg;
        end
    end

    assign m_valid        = mvalid_reg;
    assign m_rel_time_ms  = rel_reg;
    assign m_latitude_e7  = lat_reg;
    assign m_longitude_e7 = lon_reg;
endmodule
